// ===== src/sfrc_pkg.sv =====
// sfrc_pkg: shared types, constants and the crc-8 byte update for the frame receiver
// no dependencies; used by sfrc_ctrl, sfrc_datapath, the top level and the checker
`timescale 1ns / 1ps

package sfrc_pkg;

   localparam logic [7:0] SyncMask   = 8'h80;
   localparam logic [7:0] CrcPolyRst = 8'hD5;
   localparam int unsigned HeaderLen = 2;
   localparam int unsigned MinLen    = 2;

   // result event codes
   localparam logic [1:0] EvData     = 2'd0;
   localparam logic [1:0] EvCrcFail  = 2'd1;
   localparam logic [1:0] EvOverflow = 2'd2;

   // what the current byte does to the frame
   typedef enum logic [1:0] {
      OUT_NONE = 2'd0,
      OUT_OK   = 2'd1,
      OUT_FAIL = 2'd2,
      OUT_OVF  = 2'd3
   } outcome_type;

   typedef struct packed {
      logic accept;       // input item taken this cycle
      logic load_status;  // load a status result into the output register
      logic load_data;    // load the replayed frame byte into the output register
      logic rd_en;        // issue a frame store read
      logic rd_next;      // advance the replay index
   } cmd_type;

   typedef struct packed {
      outcome_type outcome;
      logic        replay_last;
   } status_type;

   function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b,
                                              logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== src/sfrc_ctrl.sv =====
// sfrc_ctrl: controller state machine for the frame receiver
// issues commands to sfrc_datapath and owns the result valid flag; uses sfrc_pkg
`timescale 1ns / 1ps

module sfrc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sfrc_pkg::status_type status,
   output sfrc_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_RECV = 3'b001,
      ST_READ = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_RECV) && out_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_RECV: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               case (status.outcome)
                  sfrc_pkg::OUT_OK: begin
                     state_in = ST_READ;
                  end
                  sfrc_pkg::OUT_FAIL, sfrc_pkg::OUT_OVF: begin
                     cmd.load_status = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               cmd.load_data = 1'b1;
               rsp_valid_in  = 1'b1;
               if (status.replay_last) begin
                  state_in = ST_RECV;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RECV;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/sfrc_datapath.sv =====
// sfrc_datapath: sync hunt, fill counter, crc-8, frame store and output register
// driven by commands from sfrc_ctrl; uses sfrc_pkg
`timescale 1ns / 1ps

module sfrc_datapath #(
   parameter int BUFFER_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sfrc_pkg::cmd_type    cmd,
   output sfrc_pkg::status_type status,
   input  logic [7:0]           rx_byte,
   input  logic                 csr_write,
   input  logic [7:0]           csr_data,
   output logic [1:0]           event_code,
   output logic [5:0]           byte_index,
   output logic [7:0]           byte_value,
   output logic                 last
);

   localparam int FillW = $clog2(BUFFER_BYTES + 1);
   localparam int AddrW = $clog2(BUFFER_BYTES);

   logic [7:0]       poly_ff;
   logic             hunting_ff, hunting_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       len_ff, len_in;
   logic [AddrW-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]       rd_data_ff;
   logic [7:0]       frame_mem_ff [BUFFER_BYTES];

   logic [1:0]       event_code_ff;
   logic [5:0]       byte_index_ff;
   logic [7:0]       byte_value_ff;
   logic             last_ff;

   logic             active, full, complete, crc_step, crc_ok, mem_we;
   logic [FillW-1:0] fill_next;
   logic [7:0]       len_cur;
   logic [8:0]       span;

   always_comb begin
      active    = !hunting_ff || ((rx_byte & sfrc_pkg::SyncMask) != 8'd0);
      full      = fill_ff == FillW'(BUFFER_BYTES);
      fill_next = fill_ff + 1'b1;
      // the length byte is still on the input when it is the second byte
      len_cur   = (fill_next == FillW'(sfrc_pkg::HeaderLen)) ? rx_byte : len_ff;
      span      = 9'(len_cur) + 9'(sfrc_pkg::HeaderLen);
      complete  = (fill_next >= FillW'(sfrc_pkg::HeaderLen)) && (9'(fill_next) == span);
      crc_step  = (9'(fill_next) > 9'(sfrc_pkg::HeaderLen)) && (9'(fill_next) < span);
      crc_ok    = (len_cur >= 8'(sfrc_pkg::MinLen)) && (crc_ff == rx_byte);
      mem_we    = cmd.accept && active && !full;

      if (!active) begin
         status.outcome = sfrc_pkg::OUT_NONE;
      end else if (full) begin
         status.outcome = sfrc_pkg::OUT_OVF;
      end else if (complete) begin
         status.outcome = crc_ok ? sfrc_pkg::OUT_OK : sfrc_pkg::OUT_FAIL;
      end else begin
         status.outcome = sfrc_pkg::OUT_NONE;
      end
      status.replay_last = 8'(rd_idx_ff) == len_ff;
   end

   always_comb begin
      hunting_in = hunting_ff;
      fill_in    = fill_ff;
      crc_in     = crc_ff;
      len_in     = len_ff;
      if (cmd.accept && active) begin
         if (full || complete) begin
            hunting_in = 1'b1;
            fill_in    = '0;
            crc_in     = 8'd0;
         end else begin
            hunting_in = 1'b0;
            fill_in    = fill_next;
            if (fill_next == FillW'(sfrc_pkg::HeaderLen)) begin
               len_in = rx_byte;
            end
            if (crc_step) begin
               crc_in = sfrc_pkg::crc8_update(crc_ff, rx_byte, poly_ff);
            end
         end
      end

      rd_idx_in = rd_idx_ff;
      if (cmd.accept) begin
         rd_idx_in = '0;
      end else if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff    <= sfrc_pkg::CrcPolyRst;
         hunting_ff <= 1'b1;
         fill_ff    <= '0;
         crc_ff     <= 8'd0;
         len_ff     <= 8'd0;
         rd_idx_ff  <= '0;
      end else begin
         if (csr_write) begin
            poly_ff <= csr_data;
         end
         hunting_ff <= hunting_in;
         fill_ff    <= fill_in;
         crc_ff     <= crc_in;
         len_ff     <= len_in;
         rd_idx_ff  <= rd_idx_in;
      end
   end

   // frame store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem_ff[fill_ff[AddrW-1:0]] <= rx_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= frame_mem_ff[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_status) begin
         event_code_ff <= (status.outcome == sfrc_pkg::OUT_OVF) ?
                          sfrc_pkg::EvOverflow : sfrc_pkg::EvCrcFail;
         byte_index_ff <= 6'd0;
         byte_value_ff <= 8'd0;
         last_ff       <= 1'b1;
      end else if (cmd.load_data) begin
         event_code_ff <= sfrc_pkg::EvData;
         byte_index_ff <= 6'(rd_idx_ff);
         byte_value_ff <= rd_data_ff;
         last_ff       <= status.replay_last;
      end
   end

   assign event_code = event_code_ff;
   assign byte_index = byte_index_ff;
   assign byte_value = byte_value_ff;
   assign last       = last_ff;

endmodule

// ===== src/serial_frame_receiver_crc8.sv =====
// serial_frame_receiver_crc8: length-prefixed link frame receiver with crc-8 check
// top level; instantiates sfrc_ctrl and sfrc_datapath, uses sfrc_pkg
// throughput: one byte per cycle while a frame fills and no result is stalled; a
// failed or dropped frame shows its status item the cycle after the byte is taken;
// a good n-length frame replays n + 1 items (store read, output load), input held off
// reset: hunting, fill count and crc cleared, polynomial 0xD5, frame store not cleared
`timescale 1ns / 1ps

module serial_frame_receiver_crc8 #(
   parameter int BUFFER_BYTES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_event_code,
   output logic [5:0] rsp_byte_index,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_crc_polynomial
);

   sfrc_pkg::cmd_type    cmd;
   sfrc_pkg::status_type status;

   assign csr_ready = 1'b1;

   sfrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfrc_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .rx_byte    (req_rx_byte),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_crc_polynomial),
      .event_code (rsp_event_code),
      .byte_index (rsp_byte_index),
      .byte_value (rsp_byte_value),
      .last       (rsp_last)
   );

endmodule

// ===== src/sfrc_checker.sv =====
// sfrc_checker: port-level assertions for serial_frame_receiver_crc8
// bound to the top level below; uses sfrc_pkg
`timescale 1ns / 1ps

module sfrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_event_code,
   input logic [5:0] rsp_byte_index,
   input logic [7:0] rsp_byte_value,
   input logic       rsp_last
);

   // index of the last taken item while a replay run is still open
   logic [5:0] run_idx_ff;
   logic       run_open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
         run_idx_ff  <= 6'd0;
      end else if (rsp_valid && rsp_ready) begin
         run_open_ff <= (rsp_event_code == sfrc_pkg::EvData) && !rsp_last;
         run_idx_ff  <= rsp_byte_index;
      end
   end

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code)
         && $stable(rsp_byte_index) && $stable(rsp_byte_value) && $stable(rsp_last))
      else $error("stalled result changed");

   // status items are single, flagged last and carry no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code != sfrc_pkg::EvData) |->
         rsp_last && (rsp_byte_index == 6'd0) && (rsp_byte_value == 8'd0))
      else $error("malformed status item");

   // an item is only taken when its result has room to land
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("item taken while output register blocked");

   // no input is taken in the middle of a replay run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_event_code == sfrc_pkg::EvData) && !rsp_last
         |=> !req_ready || (rsp_valid && rsp_last))
      else $error("input ready during frame replay");

   // a replay run advances its index by one per item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_open_ff |->
         (rsp_event_code == sfrc_pkg::EvData) && (rsp_byte_index == run_idx_ff + 6'd1))
      else $error("replay index skipped");

endmodule

bind serial_frame_receiver_crc8 sfrc_checker u_sfrc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_code (rsp_event_code),
   .rsp_byte_index (rsp_byte_index),
   .rsp_byte_value (rsp_byte_value),
   .rsp_last       (rsp_last)
);

// ===== tb/serial_frame_receiver_crc8_tb.sv =====
// serial_frame_receiver_crc8_tb: self-checking bench for the crc-8 frame receiver
// drives link bytes and polynomial writes, predicts every result item in a scoreboard
// depends on sfrc_pkg and serial_frame_receiver_crc8
`timescale 1ns / 1ps

module serial_frame_receiver_crc8_tb;

   localparam int BufBytes   = 16;
   localparam int StallLimit = 4000;
   localparam int PhaseBytes = 32;

   typedef struct packed {
      logic [1:0] event_code;
      logic [5:0] byte_index;
      logic [7:0] byte_value;
      logic       last;
   } frame_result_type;

   // tracks the parser state and holds the result items still owed by the block
   class frame_scoreboard;
      logic [7:0]       poly;
      bit               hunting;
      int unsigned      stored;
      logic [7:0]       crc_acc;
      logic [7:0]       frame_bytes [BufBytes];
      frame_result_type pending[$];
      int               errors;
      int               parsed_bytes;
      int               n_checked;
      int               n_frames;
      int               n_crc_fail;
      int               n_overflow;

      function new();
         poly = sfrc_pkg::CrcPolyRst;
         rearm_hunt();
      endfunction

      function void rearm_hunt();
         stored  = 0;
         crc_acc = 8'h00;
         hunting = 1'b1;
      endfunction

      function logic [7:0] crc8_shift_in(logic [7:0] acc, logic [7:0] b);
         logic [7:0] r;
         r = acc ^ b;
         repeat (8) r = r[7] ? ((r << 1) ^ poly) : (r << 1);
         return r;
      endfunction

      function void queue_result(logic [1:0] ev, int unsigned idx, logic [7:0] val, bit fin);
         frame_result_type r;
         r.event_code = ev;
         r.byte_index = 6'(idx);
         r.byte_value = val;
         r.last       = fin;
         pending.push_back(r);
      endfunction

      function void note_rx_byte(logic [7:0] b);
         int unsigned len;
         if (hunting && (b & sfrc_pkg::SyncMask) != 0) hunting = 1'b0;
         if (hunting) return;
         parsed_bytes++;
         // store full: this item is dropped without a look at its sync bit
         if (stored >= BufBytes) begin
            rearm_hunt();
            queue_result(sfrc_pkg::EvOverflow, 0, 8'h00, 1'b1);
            return;
         end
         frame_bytes[stored] = b;
         stored++;
         len = (stored >= sfrc_pkg::HeaderLen) ? frame_bytes[1] : 0;
         // crc runs over the payload after the header, not over the crc item itself
         if (stored > sfrc_pkg::HeaderLen && stored < sfrc_pkg::HeaderLen + len) begin
            crc_acc = crc8_shift_in(crc_acc, b);
         end
         if (stored >= sfrc_pkg::HeaderLen && stored == sfrc_pkg::HeaderLen + len) begin
            if (len >= sfrc_pkg::MinLen &&
                crc_acc == frame_bytes[(sfrc_pkg::HeaderLen + len - 1) % BufBytes]) begin
               for (int i = 0; i <= len; i++) begin
                  queue_result(sfrc_pkg::EvData, i, frame_bytes[i % BufBytes], i == len);
               end
            end else begin
               queue_result(sfrc_pkg::EvCrcFail, 0, 8'h00, 1'b1);
            end
            rearm_hunt();
         end
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         if (pending.size() == 0) begin
            $error("unexpected result: event_code %0d byte_index %0d byte_value 0x%02h last %0d",
                   got.event_code, got.byte_index, got.byte_value, got.last);
            errors++;
            return;
         end
         want = pending.pop_front();
         n_checked++;
         if (got.event_code != want.event_code) begin
            $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
            errors++;
         end
         if (got.byte_index != want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
            errors++;
         end
         if (got.byte_value != want.byte_value) begin
            $error("byte_value: expected 0x%02h, got 0x%02h", want.byte_value, got.byte_value);
            errors++;
         end
         if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
         if (want.event_code == sfrc_pkg::EvData && want.last) n_frames++;
         if (want.event_code == sfrc_pkg::EvCrcFail) n_crc_fail++;
         if (want.event_code == sfrc_pkg::EvOverflow) n_overflow++;
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_event_code;
   logic [5:0] rsp_byte_index;
   logic [7:0] rsp_byte_value;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_crc_polynomial;

   frame_scoreboard sb;
   bit gaps_on;
   bit stalls_on;
   int stall_left = 0;
   int quiet_cycles = 0;
   int bytes_sent = 0;

   serial_frame_receiver_crc8 #(
      .BUFFER_BYTES(BufBytes)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_code(rsp_event_code),
      .rsp_byte_index(rsp_byte_index),
      .rsp_byte_value(rsp_byte_value),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_crc_polynomial(csr_crc_polynomial)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // sampled mid-cycle; the item is taken at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result('{rsp_event_code, rsp_byte_index, rsp_byte_value, rsp_last});
      end
   end

   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
         $display("timeout: no handshake for %0d cycles", StallLimit);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sb.note_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      // bytes that give no result may still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic write_poly(input logic [7:0] p);
      // close any open frame so the new polynomial starts on a clean hunt
      while (!sb.hunting) send_byte(8'h00);
      drain_results();
      csr_valid          <= 1'b1;
      csr_crc_polynomial <= p;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      sb.poly = p;
   endtask

   task automatic send_random_frame();
      logic [7:0]  fr[$];
      logic [7:0]  acc;
      int unsigned kind;
      int unsigned len;
      kind = $urandom_range(0, 99);
      fr.push_back(sfrc_pkg::SyncMask | 8'($urandom));
      if (kind < 8) begin
         // line noise with the sync bit clear
         fr = {};
         repeat ($urandom_range(1, 3)) fr.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 70) begin
         len = ($urandom_range(0, 3) == 0) ?
               $urandom_range(9, BufBytes - sfrc_pkg::HeaderLen) :
               $urandom_range(sfrc_pkg::MinLen, 8);
         fr.push_back(8'(len));
         acc = 8'h00;
         repeat (len - 1) begin
            fr.push_back(8'($urandom));
            acc = sb.crc8_shift_in(acc, fr[$]);
         end
         if ($urandom_range(0, 4) == 0) acc ^= 8'($urandom_range(1, 255));
         fr.push_back(acc);
      end else if (kind < 80) begin
         len = $urandom_range(0, 1);
         fr.push_back(8'(len));
         if (len == 1) fr.push_back(8'($urandom));
      end else if (kind < 92) begin
         // length runs past the store: fill it, then one item that gets dropped
         fr.push_back(8'($urandom_range(BufBytes - sfrc_pkg::HeaderLen + 1, 255)));
         repeat (BufBytes - sfrc_pkg::HeaderLen + 1) fr.push_back(8'($urandom));
      end else begin
         // truncated frame, the next frame's bytes end up in its payload
         len = $urandom_range(4, BufBytes - sfrc_pkg::HeaderLen);
         fr.push_back(8'(len));
         repeat ($urandom_range(0, len - 2)) fr.push_back(8'($urandom));
      end
      foreach (fr[i]) send_byte(fr[i]);
   endtask

   initial begin
      logic [7:0] fr[$];
      logic [7:0] p;
      int         goal;
      req_valid          = 1'b0;
      req_rx_byte        = 8'h00;
      csr_valid          = 1'b0;
      csr_crc_polynomial = 8'h00;
      gaps_on            = 1'b1;
      stalls_on          = 1'b1;
      sb                 = new();
      reset              = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored noise, lengths 0 and 1, a minimal good frame, an overflow
      fr = {8'h00, 8'h7F, 8'h80, 8'h00, 8'hFF, 8'h01, 8'hAA, 8'h81, 8'h02, 8'hFF};
      fr.push_back(sb.crc8_shift_in(8'h00, 8'hFF));
      fr.push_back(8'hA5);
      fr.push_back(8'hFF);
      for (int i = 0; i < BufBytes - sfrc_pkg::HeaderLen; i++) begin
         fr.push_back(i[0] ? 8'hFF : 8'h00);
      end
      fr.push_back(8'hC3);
      fr.push_back(8'h01);
      foreach (fr[i]) send_byte(fr[i]);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       p = 8'h07;
            1:       p = 8'h00;
            2:       p = 8'hFF;
            3:       p = 8'($urandom);
            default: p = sfrc_pkg::CrcPolyRst;
         endcase
         write_poly(p);
         gaps_on   = (ph != 2 && ph != 4);
         stalls_on = gaps_on;
         goal      = sb.parsed_bytes + PhaseBytes;
         while (sb.parsed_bytes < goal) begin
            send_random_frame();
            if (ph == 3 && $urandom_range(0, 5) == 0) drain_results();
         end
      end

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d bytes (%0d parsed) under six polynomial settings incl. 0x00 and 0xFF",
               bytes_sent, sb.parsed_bytes);
      $display("checked %0d items: %0d good frames, %0d crc failures, %0d overflow drops",
               sb.n_checked, sb.n_frames, sb.n_crc_fail, sb.n_overflow);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sfrc_pkg.sv
src/sfrc_ctrl.sv
src/sfrc_datapath.sv
src/serial_frame_receiver_crc8.sv
src/sfrc_checker.sv
tb/serial_frame_receiver_crc8_tb.sv
